### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros: assertion helpers for the span pipeline
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property must hold at every edge
`define TSS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// condition must never be seen
`define TSS_NEVER(name, cond, msg) \
  `TSS_ASSERT(name, !(cond), msg)
`endif

### design/tss_pkg.sv
// ----------------------------------------------------------------------------
// tss_pkg: shared constants for the triangle span pipeline
// Default widths, register codes and queue depths.
// ----------------------------------------------------------------------------
package tss_pkg;
  localparam int COORD_BITS_DEF  = 16;
  localparam int SCREEN_BITS_DEF = 12;
  localparam int CFG_W           = 13;
  localparam int PAINT_W         = 8;
  localparam int MID_DEPTH       = 2;
  localparam int OUT_DEPTH       = 32;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd480;

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;
endpackage

### design/triangle_scanline_span.sv
// ----------------------------------------------------------------------------
// triangle_scanline_span: span of one triangle on one scanline
// Sorts the vertices, interpolates both edges and gives the clipped span.
// ----------------------------------------------------------------------------
// Usage:
//   Input words enter through push/full: one triangle, a row and a colour.
//   Results leave through empty/pop in order, one span word per input word.
//   The span carries a valid flag, the row, left and right columns, and the
//   colour; rows not drawn or clipped away give valid low with zero columns.
//   A word passes the front register, the middle queue, the multiply
//   register, the one-bit-per-stage edge dividers and the result queue.
//   Throughput is one word per cycle while the back end holds credits
//   from the 32-word result queue, so it never drops a finished span.
//   When pop stays low the result queue fills, the back end stops drawing from
//   the middle queue, and full rises once the front register is also held.
//   Reset empties all queues and sets the screen to 640 by 480.
//   Write screen_width (index 0) and screen_height (index 1) through the
//   cfg_we_i port only while no word is in flight.
// ----------------------------------------------------------------------------
module triangle_scanline_span
  import tss_pkg::*;
#(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int SCREEN_BITS = SCREEN_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic signed [COORD_BITS-1:0] ax_i,
  input  logic signed [COORD_BITS-1:0] ay_i,
  input  logic signed [COORD_BITS-1:0] bx_i,
  input  logic signed [COORD_BITS-1:0] by_i,
  input  logic signed [COORD_BITS-1:0] cx_i,
  input  logic signed [COORD_BITS-1:0] cy_i,
  input  logic [SCREEN_BITS-1:0]       row_i,
  input  logic [PAINT_W-1:0]           paint_i,
  output logic                         empty,
  input  logic                         pop,
  output logic                         span_valid_o,
  output logic [SCREEN_BITS-1:0]       span_row_o,
  output logic [SCREEN_BITS-1:0]       span_left_o,
  output logic [SCREEN_BITS-1:0]       span_right_o,
  output logic [PAINT_W-1:0]           span_paint_o,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [CFG_W-1:0]             cfg_wdata_i
);
  localparam int JW = SCREEN_BITS + PAINT_W + 1 + 2 * (4 * COORD_BITS + 3);
  localparam int RW = 1 + 3 * SCREEN_BITS + PAINT_W;

  logic [CFG_W-1:0] width_q, height_q;
  logic             in_ready;
  logic             f_valid, mid_full, mid_empty, mid_pop;
  logic [JW-1:0]    f_job, mid_job;
  logic [RW-1:0]    res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH:  width_q  <= cfg_wdata_i;
        CFG_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign full = !in_ready;

  tss_front #(.C(COORD_BITS), .S(SCREEN_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (push),
    .in_ready_o  (in_ready),
    .ax_i        (ax_i),
    .ay_i        (ay_i),
    .bx_i        (bx_i),
    .by_i        (by_i),
    .cx_i        (cx_i),
    .cy_i        (cy_i),
    .row_i       (row_i),
    .paint_i     (paint_i),
    .height_i    (height_q),
    .job_valid_o (f_valid),
    .job_ready_i (!mid_full),
    .job_o       (f_job)
  );

  tss_fifo #(.W(JW), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .data_i  (f_job),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_job),
    .empty_o (mid_empty)
  );

  tss_back #(.C(COORD_BITS), .S(SCREEN_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!mid_empty),
    .job_i       (mid_job),
    .job_pop_o   (mid_pop),
    .width_i     (width_q),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  assign {span_valid_o, span_row_o, span_left_o, span_right_o, span_paint_o} = res;
endmodule

### design/tss_fifo.sv
// ----------------------------------------------------------------------------
// tss_fifo: small first-in first-out word queue
// Flop storage, pointer wrap at DEPTH, push and pop in the same cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module tss_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == NW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + NW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  `TSS_ASSERT(a_fifo_cnt_range, cnt_q <= NW'(DEPTH), "fifo count beyond depth")
endmodule

### design/tss_front.sv
// ----------------------------------------------------------------------------
// tss_front: vertex sort and edge setup
// Sorts by y, decides whether the row is drawn and prepares both edges.
// ----------------------------------------------------------------------------
module tss_front
  import tss_pkg::*;
#(
  parameter int C = COORD_BITS_DEF,
  parameter int S = SCREEN_BITS_DEF,
  localparam int JW = S + PAINT_W + 1 + 2 * (4 * C + 3)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [C-1:0] ax_i,
  input  logic signed [C-1:0] ay_i,
  input  logic signed [C-1:0] bx_i,
  input  logic signed [C-1:0] by_i,
  input  logic signed [C-1:0] cx_i,
  input  logic signed [C-1:0] cy_i,
  input  logic [S-1:0]        row_i,
  input  logic [PAINT_W-1:0]  paint_i,
  input  logic [CFG_W-1:0]    height_i,
  output logic                job_valid_o,
  input  logic                job_ready_i,
  output logic [JW-1:0]       job_o
);
  localparam int EW = ((S > C) ? S : C) + 2;
  localparam int HW = ((S > CFG_W) ? S : CFG_W) + 1;

  logic signed [C-1:0]  p0x, p0y, p1x, p1y, p2x, p2y, tx, ty;
  logic signed [EW-1:0] r_e, y0e, y1e, y2e;
  logic                 drawn, use_hi;
  logic signed [C-1:0]  sxs, sys, sxe, sye;
  logic signed [C:0]    ldx, sdx;
  logic [C:0]           lmag, smag, ldyw, sdyw;
  logic [C-1:0]         loff, soff;
  logic [JW-1:0]        job_d, job_q;
  logic                 v_q;

  assign in_ready_o  = !v_q || job_ready_i;
  assign job_valid_o = v_q;
  assign job_o       = job_q;

  always_comb begin
    tx = '0;
    ty = '0;
    if (ay_i < by_i) begin
      p0x = ax_i; p0y = ay_i; p1x = bx_i; p1y = by_i;
    end else begin
      p0x = bx_i; p0y = by_i; p1x = ax_i; p1y = ay_i;
    end
    p2x = cx_i;
    p2y = cy_i;
    if (p1y > p2y) begin
      tx = p1x; ty = p1y;
      p1x = p2x; p1y = p2y;
      p2x = tx; p2y = ty;
    end
    if (p0y > p1y) begin
      tx = p0x; ty = p0y;
      p0x = p1x; p0y = p1y;
      p1x = tx; p1y = ty;
    end

    r_e = signed'(EW'(row_i));
    y0e = EW'(p0y);
    y1e = EW'(p1y);
    y2e = EW'(p2y);
    drawn = (p0y < p2y) && (r_e >= y0e) && (r_e <= y2e) && (HW'(row_i) < HW'(height_i));

    use_hi = (r_e >= y1e);
    sxs = use_hi ? p1x : p0x;
    sys = use_hi ? p1y : p0y;
    sxe = use_hi ? p2x : p1x;
    sye = use_hi ? p2y : p1y;

    loff = C'(r_e - y0e);
    soff = use_hi ? C'(r_e - y1e) : C'(r_e - y0e);

    ldx  = (C+1)'(p2x) - (C+1)'(p0x);
    sdx  = (C+1)'(sxe) - (C+1)'(sxs);
    lmag = ldx[C] ? (~ldx + (C+1)'(2)) : (ldx + (C+1)'(1));
    smag = sdx[C] ? (~sdx + (C+1)'(2)) : (sdx + (C+1)'(1));
    ldyw = (C+1)'(p2y) - (C+1)'(p0y) + (C+1)'(1);
    sdyw = (C+1)'(sye) - (C+1)'(sys) + (C+1)'(1);

    job_d = {row_i, paint_i, drawn,
             p0x, loff, lmag, ldx[C], ldyw,
             sxs, soff, smag, sdx[C], sdyw};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      job_q <= job_d;
    end
  end
endmodule

### design/tss_div.sv
// ----------------------------------------------------------------------------
// tss_div: pipelined restoring divider
// One quotient bit per stage, most significant first, with sideband.
// ----------------------------------------------------------------------------
module tss_div #(
  parameter int NW = 33,
  parameter int DW = 17,
  parameter int QW = 17,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quot_o,
  output logic [SW-1:0] side_o
);
  logic          v_q    [QW];
  logic [NW-1:0] rem_q  [QW];
  logic [QW-1:0] quot_q [QW];
  logic [DW-1:0] den_q  [QW];
  logic [SW-1:0] side_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int K = QW - 1 - s;
    logic          v_in;
    logic [NW-1:0] rem_in, shifted;
    logic [QW-1:0] quot_in;
    logic [DW-1:0] den_in;
    logic [SW-1:0] side_in;
    logic          ge;

    if (s == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = num_i;
      assign quot_in = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign quot_in = quot_q[s-1];
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
    end

    assign shifted = NW'(den_in) << K;
    assign ge      = rem_in >= shifted;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= ge ? (rem_in - shifted) : rem_in;
      quot_q[s] <= quot_in | (ge ? (QW'(1) << K) : '0);
      den_q[s]  <= den_in;
      side_q[s] <= side_in;
    end
  end

  assign valid_o = v_q[QW-1];
  assign quot_o  = quot_q[QW-1];
  assign side_o  = side_q[QW-1];
endmodule

### design/tss_back.sv
// ----------------------------------------------------------------------------
// tss_back: edge interpolation, clipping and result queue
// Multiply, divide both edges, clip to the screen, queue the span.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module tss_back
  import tss_pkg::*;
#(
  parameter int C = COORD_BITS_DEF,
  parameter int S = SCREEN_BITS_DEF,
  localparam int JW = S + PAINT_W + 1 + 2 * (4 * C + 3),
  localparam int RW = 1 + 3 * S + PAINT_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  input  logic [JW-1:0]    job_i,
  output logic             job_pop_o,
  input  logic [CFG_W-1:0] width_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [RW-1:0]    res_o
);
  localparam int NW  = 2 * C + 1;
  localparam int QW  = C + 1;
  localparam int CW  = $clog2(OUT_DEPTH + 1);
  localparam int LSW = S + PAINT_W + 1 + 1 + C;
  localparam int SSW = 1 + C;
  localparam int MX  = (C + 2 > S + 2) ? C + 2 : S + 2;
  localparam int CLW = ((MX > CFG_W + 1) ? MX : CFG_W + 1) + 1;

  logic [S-1:0]        j_row;
  logic [PAINT_W-1:0]  j_paint;
  logic                j_drawn, j_lneg, j_sneg;
  logic signed [C-1:0] j_lxs, j_sxs;
  logic [C-1:0]        j_loff, j_soff;
  logic [C:0]          j_lmag, j_smag, j_ldyw, j_sdyw;

  logic            take, out_full, out_pop;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            m_v_q;
  logic [NW-1:0]   m_lprod_q, m_sprod_q;
  logic [C:0]      m_ldyw_q, m_sdyw_q;
  logic [LSW-1:0]  m_lside_q, d_lside;
  logic [SSW-1:0]  m_sside_q, d_sside;
  logic            d_v, d_sv;
  logic [QW-1:0]   d_lq, d_sq;

  logic [S-1:0]         o_row;
  logic [PAINT_W-1:0]   o_paint;
  logic                 o_drawn, o_lneg, o_sneg;
  logic signed [C-1:0]  o_lxs, o_sxs;
  logic signed [CLW-1:0] xa, xb, lo, hi, wl, lim;
  logic                 o_valid;
  logic [S-1:0]         o_left, o_right;

  assign {j_row, j_paint, j_drawn,
          j_lxs, j_loff, j_lmag, j_lneg, j_ldyw,
          j_sxs, j_soff, j_smag, j_sneg, j_sdyw} = job_i;

  assign take      = job_valid_i && (cnt_q < CW'(OUT_DEPTH));
  assign job_pop_o = take;
  assign out_pop   = pop_i && !empty_o;

  always_comb begin
    cnt_d = cnt_q;
    if (take && !out_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (out_pop && !take) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      m_v_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      m_v_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    m_lprod_q <= NW'(j_loff) * NW'(j_lmag);
    m_sprod_q <= NW'(j_soff) * NW'(j_smag);
    m_ldyw_q  <= j_ldyw;
    m_sdyw_q  <= j_sdyw;
    m_lside_q <= {j_row, j_paint, j_drawn, j_lneg, j_lxs};
    m_sside_q <= {j_sneg, j_sxs};
  end

  tss_div #(.NW(NW), .DW(C + 1), .QW(QW), .SW(LSW)) u_div_long (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (m_v_q),
    .num_i   (m_lprod_q),
    .den_i   (m_ldyw_q),
    .side_i  (m_lside_q),
    .valid_o (d_v),
    .quot_o  (d_lq),
    .side_o  (d_lside)
  );

  tss_div #(.NW(NW), .DW(C + 1), .QW(QW), .SW(SSW)) u_div_short (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (m_v_q),
    .num_i   (m_sprod_q),
    .den_i   (m_sdyw_q),
    .side_i  (m_sside_q),
    .valid_o (d_sv),
    .quot_o  (d_sq),
    .side_o  (d_sside)
  );

  assign {o_row, o_paint, o_drawn, o_lneg, o_lxs} = d_lside;
  assign {o_sneg, o_sxs} = d_sside;

  always_comb begin
    xa  = o_lneg ? (CLW'(o_lxs) - signed'(CLW'(d_lq))) : (CLW'(o_lxs) + signed'(CLW'(d_lq)));
    xb  = o_sneg ? (CLW'(o_sxs) - signed'(CLW'(d_sq))) : (CLW'(o_sxs) + signed'(CLW'(d_sq)));
    lim = signed'(CLW'(1) << S);
    wl  = signed'(CLW'(width_i));
    if (wl > lim) begin
      wl = lim;
    end
    lo = (xa < xb) ? xa : xb;
    hi = (xa < xb) ? xb : xa;
    if (lo < 0) begin
      lo = '0;
    end
    if (hi > wl - CLW'(1)) begin
      hi = wl - CLW'(1);
    end
    o_valid = o_drawn && (lo <= hi);
    o_left  = o_valid ? lo[S-1:0] : '0;
    o_right = o_valid ? hi[S-1:0] : '0;
  end

  tss_fifo #(.W(RW), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (d_v),
    .data_i  ({o_valid, o_row, o_left, o_right, o_paint}),
    .full_o  (out_full),
    .pop_i   (out_pop),
    .data_o  (res_o),
    .empty_o (empty_o)
  );

  `TSS_ASSERT(a_credit_bound, cnt_q <= CW'(OUT_DEPTH), "credit count beyond queue depth")
  `TSS_NEVER(a_out_room, d_v && out_full, "span arrived with result queue full")
  `TSS_NEVER(a_div_lockstep, d_v != d_sv, "edge dividers out of step")
endmodule

### tb/sv/triangle_scanline_span_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_scanline_span_tb: self-checking bench for the scanline span block
// Drives triangle/row words through push/full and checks every span word
// popped against an in-bench span calculator or a fixed expected word,
// over several screen sizes, with random idling on both sides and a long receiver hold-off.
// ----------------------------------------------------------------------------
module triangle_scanline_span_tb;
  import tss_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int SB = SCREEN_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic signed [CB-1:0] ax, ay, bx, by, cx, cy;
    logic [SB-1:0]        row;
    logic [PAINT_W-1:0]   paint;
  } tri_word_t;

  typedef struct packed {
    logic               valid;
    logic [SB-1:0]      row;
    logic [SB-1:0]      left;
    logic [SB-1:0]      right;
    logic [PAINT_W-1:0] paint;
  } span_word_t;

  typedef struct packed {
    tri_word_t  w;
    logic       fixed;
    span_word_t s;
  } dir_row_t;

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic push = 1'b0, pop = 1'b0;
  logic full, empty;
  tri_word_t drv = '0;
  logic span_valid_o;
  logic [SB-1:0] span_row_o, span_left_o, span_right_o;
  logic [PAINT_W-1:0] span_paint_o;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = CFG_WIDTH;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  logic [CFG_W-1:0] scr_width = WIDTH_RST, scr_height = HEIGHT_RST;
  span_word_t span_q[$];
  dir_row_t dir_tab[$];
  int errors = 0, n_sent = 0, n_popped = 0, n_drawn = 0, idle_cnt = 0;
  bit quiet = 1'b0;

  triangle_scanline_span DUT (
    .clk_i, .rst_ni, .push, .full,
    .ax_i(drv.ax), .ay_i(drv.ay), .bx_i(drv.bx), .by_i(drv.by),
    .cx_i(drv.cx), .cy_i(drv.cy), .row_i(drv.row), .paint_i(drv.paint),
    .empty, .pop, .span_valid_o, .span_row_o, .span_left_o, .span_right_o,
    .span_paint_o, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic longint widen(longint d);
    return d >= 0 ? d + 1 : d - 1;
  endfunction

  function automatic longint edge_at(longint xs, longint ys, longint xe, longint ye,
                                     longint r);
    return (r - ys) * widen(xe - xs) / (ye - ys + 1) + xs;
  endfunction

  function automatic span_word_t calc_span(tri_word_t w);
    longint x0, y0, x1, y1, x2, y2, t, r, xa, xb, lo, hi, wl;
    span_word_t s;
    s = '0;
    s.row = w.row;
    s.paint = w.paint;
    r = w.row;
    if (w.ay < w.by) begin
      x0 = w.ax; y0 = w.ay; x1 = w.bx; y1 = w.by;
    end else begin
      x0 = w.bx; y0 = w.by; x1 = w.ax; y1 = w.ay;
    end
    x2 = w.cx; y2 = w.cy;
    if (y1 > y2) begin
      t = x1; x1 = x2; x2 = t; t = y1; y1 = y2; y2 = t;
    end
    if (y0 > y1) begin
      t = x0; x0 = x1; x1 = t; t = y0; y0 = y1; y1 = t;
    end
    wl = scr_width > (1 << SB) ? (1 << SB) : scr_width;
    if (y0 < y2 && r >= y0 && r <= y2 && r < scr_height) begin
      xa = edge_at(x0, y0, x2, y2, r);
      if (r < y1) xb = edge_at(x0, y0, x1, y1, r);
      else if (r == y1) xb = x1;
      else xb = edge_at(x1, y1, x2, y2, r);
      lo = xa < xb ? xa : xb;
      hi = xa < xb ? xb : xa;
      if (lo < 0) lo = 0;
      if (hi > wl - 1) hi = wl - 1;
      if (lo <= hi) begin
        s.valid = 1'b1;
        s.left = lo[SB-1:0];
        s.right = hi[SB-1:0];
      end
    end
    return s;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_WIDTH) scr_width = val;
    else scr_height = val;
    @(posedge clk_i);
  endtask

  task automatic send_word(tri_word_t w, bit fixed, span_word_t s);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    push <= 1'b1;
    drv <= w;
    do @(posedge clk_i); while (!(push && !full));
    span_q.push_back(fixed ? s : calc_span(w));
    n_sent++;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (span_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  function automatic logic signed [CB-1:0] rnd_coord(int lo, int hi);
    if ($urandom_range(0, 7) == 0) return CB'($urandom);
    return CB'($urandom_range(0, hi - lo) + lo);
  endfunction

  task automatic random_words(int n);
    tri_word_t w;
    int wlim, hlim, ymin, ymax;
    wlim = scr_width > 4096 ? 4096 : scr_width;
    hlim = scr_height > 4096 ? 4096 : scr_height;
    repeat (n) begin
      w.ax = rnd_coord(-200, wlim + 200);
      w.bx = rnd_coord(-200, wlim + 200);
      w.cx = rnd_coord(-200, wlim + 200);
      w.ay = rnd_coord(-60, hlim + 60);
      w.by = rnd_coord(-60, hlim + 60);
      w.cy = rnd_coord(-60, hlim + 60);
      if ($urandom_range(0, 9) == 0) w.by = w.ay;
      if ($urandom_range(0, 9) == 0) w.cy = w.by;
      ymin = w.ay < w.by ? (w.ay < w.cy ? w.ay : w.cy) : (w.by < w.cy ? w.by : w.cy);
      ymax = w.ay > w.by ? (w.ay > w.cy ? w.ay : w.cy) : (w.by > w.cy ? w.by : w.cy);
      if (ymin < 0) ymin = 0;
      if (ymax > 4095) ymax = 4095;
      if ($urandom_range(0, 4) != 0 && ymin <= ymax) w.row = SB'($urandom_range(ymin, ymax));
      else w.row = SB'($urandom);
      w.paint = PAINT_W'($urandom);
      send_word(w, 1'b0, '0);
    end
  endtask

  initial begin
    dir_tab.push_back('{'{16'sd10, 16'sd5, 16'sd50, 16'sd5, 16'sd90, 16'sd5, 12'd5, 8'h11},
                        1'b1, '{1'b0, 12'd5, 12'd0, 12'd0, 8'h11}});
    dir_tab.push_back('{'{16'sd10, 16'sd10, 16'sd50, 16'sd20, 16'sd90, 16'sd15, 12'd5, 8'h22},
                        1'b1, '{1'b0, 12'd5, 12'd0, 12'd0, 8'h22}});
    dir_tab.push_back('{'{16'sd0, 16'sd0, 16'sd0, 16'sd32767, 16'sd10, 16'sd0, 12'd4095, 8'hff},
                        1'b1, '{1'b0, 12'd4095, 12'd0, 12'd0, 8'hff}});
    dir_tab.push_back('{'{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768,
                        16'sd32767, 12'd0, 8'h00}, 1'b0, '0});
    dir_tab.push_back('{'{16'sd32767, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768,
                        16'sd0, 12'd479, 8'h80}, 1'b0, '0});
    dir_tab.push_back('{'{16'sd100, 16'sd0, 16'sd300, 16'sd50, 16'sd10, 16'sd100, 12'd50, 8'h01},
                        1'b0, '0});
    dir_tab.push_back('{'{16'sd100, 16'sd0, 16'sd300, 16'sd50, 16'sd10, 16'sd100, 12'd70, 8'h02},
                        1'b0, '0});
    dir_tab.push_back('{'{16'sd100, -16'sd40, 16'sd300, -16'sd10, 16'sd10, 16'sd100, 12'd0,
                        8'h04}, 1'b0, '0});
    dir_tab.push_back('{'{16'sd300, 16'sd20, 16'sd100, 16'sd20, 16'sd200, 16'sd80, 12'd20,
                        8'h08}, 1'b0, '0});
    dir_tab.push_back('{'{16'sd300, 16'sd80, 16'sd100, 16'sd80, 16'sd200, 16'sd20, 12'd80,
                        8'h10}, 1'b0, '0});
    dir_tab.push_back('{'{-16'sd500, 16'sd0, -16'sd400, 16'sd30, -16'sd300, 16'sd60, 12'd30,
                        8'h20}, 1'b0, '0});
    dir_tab.push_back('{'{16'sd2000, 16'sd0, 16'sd5000, 16'sd30, 16'sd900, 16'sd60, 12'd30,
                        8'h40}, 1'b0, '0});
    dir_tab.push_back('{'{16'sd0, 16'sd0, 16'sd639, 16'sd479, 16'sd639, 16'sd0, 12'd479, 8'haa},
                        1'b0, '0});
    dir_tab.push_back('{'{16'sd0, 16'sd0, 16'sd639, 16'sd479, 16'sd639, 16'sd0, 12'd480, 8'h55},
                        1'b1, '{1'b0, 12'd480, 12'd0, 12'd0, 8'h55}});

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_tab[i]) send_word(dir_tab[i].w, dir_tab[i].fixed, dir_tab[i].s);
    drain();

    write_reg(CFG_WIDTH, 13'd4096);
    write_reg(CFG_HEIGHT, 13'd4096);
    random_words(200);
    drain();
    write_reg(CFG_WIDTH, 13'd1);
    write_reg(CFG_HEIGHT, 13'd1);
    random_words(100);
    drain();
    write_reg(CFG_WIDTH, 13'd0);
    write_reg(CFG_HEIGHT, 13'd8191);
    random_words(80);
    drain();
    write_reg(CFG_WIDTH, 13'd8191);
    write_reg(CFG_HEIGHT, 13'd0);
    random_words(60);
    drain();
    write_reg(CFG_WIDTH, 13'd640);
    write_reg(CFG_HEIGHT, 13'd480);
    random_words(300);
    drain();
    write_reg(CFG_WIDTH, 13'($urandom_range(1, 4096)));
    write_reg(CFG_HEIGHT, 13'($urandom_range(1, 4096)));
    random_words(150);
    drain();
    quiet = 1'b1;
    write_reg(CFG_WIDTH, 13'd64);
    write_reg(CFG_HEIGHT, 13'd48);
    random_words(150);
    drain();

    $display("Sent %0d words over seven screen sizes, %0d spans popped, %0d drawn.",
             n_sent, n_popped, n_drawn);
    $display("Covered extremes, ties, zero/wide screens, idling and a full-queue stall.");
    if (errors == 0) begin
      $display("** triangle_scanline_span: PASSED **");
    end else begin
      $display("** triangle_scanline_span: FAILED **");
    end
    $finish;
  end

  // receiver: random stalls, one long hold-off, none in the quiet part
  initial begin
    int stall;
    bit held;
    stall = 0;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        span_word_t e;
        n_popped++;
        if (span_valid_o) n_drawn++;
        if (span_q.size() == 0) begin
          $display("%0t: span word with none expected: %h", $time,
                   {span_valid_o, span_row_o, span_left_o, span_right_o, span_paint_o});
          errors++;
        end else begin
          e = span_q.pop_front();
          if (span_valid_o !== e.valid) begin
            $display("%0t: valid exp %0d got %0d", $time, e.valid, span_valid_o); errors++;
          end
          if (span_row_o !== e.row) begin
            $display("%0t: row exp %0d got %0d", $time, e.row, span_row_o); errors++;
          end
          if (span_left_o !== e.left) begin
            $display("%0t: left exp %0d got %0d", $time, e.left, span_left_o); errors++;
          end
          if (span_right_o !== e.right) begin
            $display("%0t: right exp %0d got %0d", $time, e.right, span_right_o); errors++;
          end
          if (span_paint_o !== e.paint) begin
            $display("%0t: paint exp %h got %h", $time, e.paint, span_paint_o); errors++;
          end
        end
      end
      if (!held && n_sent >= 300) begin
        held = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        pop <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 13) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d spans pending", $time, span_q.size());
      $display("** triangle_scanline_span: FAILED **");
      $finish;
    end
  end
endmodule
